// ===== src/pba_pkg.sv =====
// Shared types, constants and helpers for the packed bitfield array.
package pba_pkg;

    localparam int IDX_W      = 12;
    localparam int BITS_W     = 6;
    localparam int COUNT_W    = 13;
    localparam int DATA_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int START_W    = IDX_W + BITS_W;
    localparam int SH_W       = 5;
    localparam int WIN_W      = 2 * DATA_W;

    localparam logic [BITS_W-1:0]  BITS_RESET  = 6'd8;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd0;

    // Configuration register indexes.
    localparam logic REG_ELEMENT_BITS  = 1'b0;
    localparam logic REG_ELEMENT_COUNT = 1'b1;

    // Opcodes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // word accepted: latch it and start the bank reads
        logic exec;    // merge, write back, load the output register
        logic cfg_we;  // configuration write
    } pba_cmd_t;

    // Width saturated to 1..32.
    function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] b);
        logic [BITS_W-1:0] r;
        r = b;
        if (b == '0) r = 6'd1;
        else if (b > 6'd32) r = 6'd32;
        return r;
    endfunction

    // Low-aligned element mask for an effective width of 1..32.
    function automatic logic [DATA_W-1:0] elem_mask(input logic [BITS_W-1:0] b);
        logic [DATA_W-1:0] m;
        if (b >= 6'd32) m = '1;
        else m = (DATA_W'(1) << b) - DATA_W'(1);
        return m;
    endfunction

endpackage

// ===== src/packed_bitfield_array.sv =====
// Top level of the packed bitfield array: controller plus datapath.
//
// Usage:
//   Input channel (s_valid/s_ready): one word is one access, s_opcode
//   selects read or write of element s_element_index; s_write_value is
//   stored on a write (bits above the width dropped).
//   Result channel (m_valid/m_ready): one word per access, m_read_value
//   holds the zero-extended element on a good read, zero otherwise;
//   m_range_error flags an index at/over element_count or past the store.
//   Config channel (cfg_valid/cfg_ready): index 0 = element_bits,
//   index 1 = element_count. Write only while the block is idle.
//   Sequencing: an accepted word executes when the output is free; the next
//   word is accepted only after that, as the registered read of the two word
//   banks is followed by the write-back of the merged window.
//   Reset: synchronous on aresetn low; element_bits = 8, element_count = 0,
//   result channel empty. Store contents are undefined until written.
//   Stall: a waiting result sits in the output register while the next
//   word is accepted; that word's execute step holds until the register
//   is taken.
module packed_bitfield_array #(
    parameter int STORE_BYTES = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // access words in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [pba_pkg::IDX_W-1:0]      s_element_index,
    input  logic [pba_pkg::DATA_W-1:0]     s_write_value,
    // result words out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pba_pkg::DATA_W-1:0]     m_read_value,
    output logic                           m_range_error,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0] cfg_data
);

    pba_pkg::pba_cmd_t cmd;

    // sequencing: IDLE accepts, EXEC merges and loads the output register
    pba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // offset math, two 32-bit word banks (even/odd) and the output register
    pba_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_opcode        (s_opcode),
        .s_element_index (s_element_index),
        .s_write_value   (s_write_value),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_read_value    (m_read_value),
        .m_range_error   (m_range_error)
    );

endmodule

// ===== src/pba_ctrl.sv =====
// Controller: accept/execute sequencing and output-register occupancy.
module pba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output pba_pkg::pba_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        out_full_next = out_full_reg && !m_ready;
        cmd.cfg_we = cfg_valid;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // output register free or draining this cycle
                if (!out_full_reg || m_ready) begin
                    cmd.exec      = 1'b1;
                    out_full_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_full_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== src/pba_datapath.sv =====
// Datapath: config registers, offset math, banked word store, merge and result.
module pba_datapath #(
    parameter int STORE_BYTES = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pba_pkg::pba_cmd_t                cmd,
    input  logic                             s_opcode,
    input  logic [pba_pkg::IDX_W-1:0]        s_element_index,
    input  logic [pba_pkg::DATA_W-1:0]       s_write_value,
    input  logic                             cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [pba_pkg::DATA_W-1:0]       m_read_value,
    output logic                             m_range_error
);

    localparam int TOTAL_BITS = STORE_BYTES * 8;
    localparam int BANK_DEPTH = (STORE_BYTES + 7) / 8;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int LIM_W      = $clog2(TOTAL_BITS + 1);
    localparam int CMP_W      = (LIM_W > pba_pkg::START_W + 1) ? LIM_W : pba_pkg::START_W + 1;

    // configuration
    logic [pba_pkg::BITS_W-1:0]  bits_cfg_reg;
    logic [pba_pkg::COUNT_W-1:0] count_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_cfg_reg  <= pba_pkg::BITS_RESET;
            count_cfg_reg <= pba_pkg::COUNT_RESET;
        end else if (cmd.cfg_we) begin
            if (cfg_index == pba_pkg::REG_ELEMENT_BITS)
                bits_cfg_reg <= cfg_data[pba_pkg::BITS_W-1:0];
            else
                count_cfg_reg <= cfg_data[pba_pkg::COUNT_W-1:0];
        end
    end

    // offset and range check on the incoming word
    logic [pba_pkg::BITS_W-1:0] bits_c;
    logic [CMP_W-1:0]           start_c;
    logic [CMP_W-1:0]           end_c;
    logic                       err_c;
    logic [AW:0]                b0_full_c;
    logic [AW-1:0]              b0_addr_c;
    logic [AW-1:0]              b1_addr_c;
    logic                       hi_ok_c;

    always_comb begin
        bits_c    = pba_pkg::eff_bits(bits_cfg_reg);
        start_c   = CMP_W'(pba_pkg::START_W'(s_element_index) * pba_pkg::START_W'(bits_c));
        end_c     = start_c + CMP_W'(bits_c);
        err_c     = ({1'b0, s_element_index} >= count_cfg_reg) ||
                    (end_c > CMP_W'(TOTAL_BITS));
        // word w = start/32; even words in bank 0, odd words in bank 1
        b1_addr_c = start_c[6 +: AW];
        b0_full_c = {1'b0, start_c[6 +: AW]} + (AW + 1)'(start_c[5]);
        b0_addr_c = b0_full_c[AW-1:0];
        hi_ok_c   = (b0_full_c < (AW + 1)'(BANK_DEPTH));
    end

    // latched item
    logic                        op_reg;
    logic [pba_pkg::DATA_W-1:0]  wval_reg;
    logic [pba_pkg::BITS_W-1:0]  bits_reg;
    logic [pba_pkg::SH_W-1:0]    sh_reg;
    logic                        err_reg;
    logic                        w0_reg;
    logic                        hi_ok_reg;
    logic [AW-1:0]               b0_addr_reg;
    logic [AW-1:0]               b1_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_opcode;
            wval_reg    <= s_write_value;
            bits_reg    <= bits_c;
            sh_reg      <= start_c[pba_pkg::SH_W-1:0];
            err_reg     <= err_c;
            w0_reg      <= start_c[5];
            hi_ok_reg   <= hi_ok_c;
            b0_addr_reg <= b0_addr_c;
            b1_addr_reg <= b1_addr_c;
        end
    end

    // word banks
    logic [pba_pkg::DATA_W-1:0] bank0_mem [BANK_DEPTH];
    logic [pba_pkg::DATA_W-1:0] bank1_mem [BANK_DEPTH];
    logic [pba_pkg::DATA_W-1:0] b0_q_reg;
    logic [pba_pkg::DATA_W-1:0] b1_q_reg;
    logic                       we0, we1;
    logic [pba_pkg::DATA_W-1:0] wd0, wd1;

    always_ff @(posedge aclk) begin
        if (cmd.load) b0_q_reg <= bank0_mem[b0_addr_c];
        if (we0) bank0_mem[b0_addr_reg] <= wd0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) b1_q_reg <= bank1_mem[b1_addr_c];
        if (we1) bank1_mem[b1_addr_reg] <= wd1;
    end

    // merge
    logic [pba_pkg::DATA_W-1:0] mask_c;
    logic [pba_pkg::WIN_W-1:0]  win_c;
    logic [pba_pkg::WIN_W-1:0]  win_mask_c;
    logic [pba_pkg::WIN_W-1:0]  win_new_c;
    logic [pba_pkg::WIN_W-1:0]  win_sh_c;
    logic [pba_pkg::DATA_W-1:0] field_c;
    logic                       we_c;

    always_comb begin
        mask_c     = pba_pkg::elem_mask(bits_reg);
        win_c      = w0_reg ? {b0_q_reg, b1_q_reg} : {b1_q_reg, b0_q_reg};
        win_sh_c   = win_c >> sh_reg;
        field_c    = win_sh_c[pba_pkg::DATA_W-1:0] & mask_c;
        win_mask_c = {{pba_pkg::DATA_W{1'b0}}, mask_c} << sh_reg;
        win_new_c  = (win_c & ~win_mask_c) |
                     ({{pba_pkg::DATA_W{1'b0}}, wval_reg & mask_c} << sh_reg);
        we_c       = cmd.exec && (op_reg == pba_pkg::OP_WRITE) && !err_reg;
        // low word lives in bank w[0], high word in the other bank
        we0 = we_c && (!w0_reg || hi_ok_reg);
        we1 = we_c;
        wd0 = w0_reg ? win_new_c[pba_pkg::WIN_W-1:pba_pkg::DATA_W]
                     : win_new_c[pba_pkg::DATA_W-1:0];
        wd1 = w0_reg ? win_new_c[pba_pkg::DATA_W-1:0]
                     : win_new_c[pba_pkg::WIN_W-1:pba_pkg::DATA_W];
    end

    // output register
    logic [pba_pkg::DATA_W-1:0] read_value_reg;
    logic                       range_error_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            read_value_reg  <= ((op_reg == pba_pkg::OP_READ) && !err_reg) ? field_c : '0;
            range_error_reg <= err_reg;
        end
    end

    assign m_read_value  = read_value_reg;
    assign m_range_error = range_error_reg;

endmodule

// ===== src/pba_checker.sv =====
// Port-level checks for the packed bitfield array, bound to the top level.
module pba_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [pba_pkg::DATA_W-1:0] m_read_value,
    input logic                       m_range_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_range_error))
        else $error("result changed while stalled");

    // rejected access returns zero data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_read_value == '0)
        else $error("range error with nonzero data");

    // result channel empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted access occupies the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back to back");

endmodule

bind packed_bitfield_array pba_checker u_pba_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_value  (m_read_value),
    .m_range_error (m_range_error)
);
